/* rtl/lkv_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package lkv_pkg;

    localparam int ENTRIES    = 16;
    localparam int KEY_BITS   = 16;
    localparam int VALUE_BITS = 64;
    localparam int CAP_BITS   = 5;
    localparam int CNT_BITS   = $clog2(ENTRIES + 1);
    localparam int CMP_BITS   = (CNT_BITS > CAP_BITS) ? CNT_BITS : CAP_BITS;

    localparam logic [CAP_BITS-1:0] CAP_RESET = CAP_BITS'(16);

    localparam logic CMD_GET = 1'b0;
    localparam logic CMD_PUT = 1'b1;

    typedef struct packed {
        logic                  cmd;
        logic [KEY_BITS-1:0]   key;
        logic [VALUE_BITS-1:0] value;
    } t_req;

    typedef struct packed {
        logic                  hit;
        logic [VALUE_BITS-1:0] read_value;
    } t_rsp;

    typedef struct packed {
        logic                  valid;
        logic [KEY_BITS-1:0]   key;
        logic [VALUE_BITS-1:0] data;
    } t_entry;

    typedef struct packed {
        logic look;     // compare the broadcast key and latch the match
        logic update;   // move entries along the chain
        logic ins_all;  // new key: every cell takes its neighbor's entry
    } t_cell_ctl;

endpackage

`default_nettype wire

/* rtl/lru_key_value_cache.sv */
// Commands are taken only while idle. Each steps through accept, key compare across the
// cell chain (LOOK) and chain update (UPD); busy is high during compare and update. The
// result is registered in UPD and strobed on o_rsp for one cycle.
// Reset (synchronous, active low) empties the cache and sets capacity to 16.
// The result strobe lasts one cycle; the receiver cannot stall.
`timescale 1ns / 1ps
`default_nettype none

module lru_key_value_cache import lkv_pkg::*; (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                start,
    output logic                     busy,
    input  wire t_req                i_req,
    output logic                     o_rsp_valid,
    output t_rsp                     o_rsp,
    input  wire logic                i_cfg_valid,
    output logic                     o_cfg_ready,
    input  wire logic [CAP_BITS-1:0] i_cfg_data
);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_LOOK = 3'b010,
        ST_UPD  = 3'b100
    } t_state;

    t_state                r_state;
    t_state                n_state;
    t_req                  r_req;
    logic [CAP_BITS-1:0]   r_cap;
    logic [CNT_BITS-1:0]   r_count;
    logic                  r_rsp_valid;
    t_rsp                  r_rsp;

    t_cell_ctl             w_ctl;
    t_entry                w_new;
    t_entry                w_entry [ENTRIES];
    logic                  w_shift [ENTRIES];
    t_entry                w_sel   [ENTRIES];
    logic                  w_hit;
    logic                  w_evict;
    logic                  w_do_ins;
    logic [CMP_BITS-1:0]   w_cap_eff;
    logic [CMP_BITS-1:0]   w_count_ext;

    assign busy        = (r_state != ST_IDLE);
    assign o_cfg_ready = 1'b1;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (start) begin
                    n_state = ST_LOOK;
                end
            end
            ST_LOOK: n_state = ST_UPD;
            ST_UPD:  n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    // Capacity above the cell count acts as a full cache.
    assign w_cap_eff   = (CMP_BITS'(r_cap) > CMP_BITS'(ENTRIES)) ?
                         CMP_BITS'(ENTRIES) : CMP_BITS'(r_cap);
    assign w_count_ext = CMP_BITS'(r_count);
    assign w_evict     = (w_count_ext >= w_cap_eff);
    assign w_hit       = w_sel[0].valid;
    // Zero capacity on an empty cache: insert and evict at once, so skip.
    assign w_do_ins    = (r_req.cmd == CMD_PUT) && !w_hit
                         && !(w_evict && (r_count == '0));

    assign w_ctl.look    = (r_state == ST_LOOK);
    assign w_ctl.update  = (r_state == ST_UPD) && (w_hit || w_do_ins);
    assign w_ctl.ins_all = !w_hit;

    assign w_new.valid = 1'b1;
    assign w_new.key   = r_req.key;
    assign w_new.data  = (r_req.cmd == CMD_PUT) ? r_req.value : w_sel[0].data;

    for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
        logic   w_prev_shift;
        t_entry w_prev_sel;
        t_entry w_prev_entry;
        logic   w_drop;

        if (g == 0) begin : g_head
            assign w_prev_entry = w_new;
        end else begin : g_body
            assign w_prev_entry = w_entry[g-1];
        end

        if (g == ENTRIES - 1) begin : g_tail
            assign w_prev_shift = 1'b0;
            assign w_prev_sel   = '0;
        end else begin : g_mid
            assign w_prev_shift = w_shift[g+1];
            assign w_prev_sel   = w_sel[g+1];
        end

        // On eviction the least recent entry lands here after the shift; drop it.
        assign w_drop = w_evict && (r_count == CNT_BITS'(g));

        lkv_cell u_cell (
            .i_clk         (i_clk),
            .i_rst_n       (i_rst_n),
            .i_ctl         (w_ctl),
            .i_key         (r_req.key),
            .i_drop        (w_drop),
            .i_prev        (w_prev_entry),
            .i_shift_above (w_prev_shift),
            .i_sel_above   (w_prev_sel),
            .o_entry       (w_entry[g]),
            .o_shift       (w_shift[g]),
            .o_sel         (w_sel[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_cap       <= CAP_RESET;
            r_count     <= '0;
            r_rsp_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_rsp_valid <= (r_state == ST_UPD);
            if (i_cfg_valid && o_cfg_ready) begin
                r_cap <= i_cfg_data;
            end
            if ((r_state == ST_UPD) && w_do_ins && !w_evict) begin
                r_count <= r_count + CNT_BITS'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == ST_IDLE) && start) begin
            r_req <= i_req;
        end
        if (r_state == ST_UPD) begin
            r_rsp.hit        <= w_hit;
            r_rsp.read_value <= ((r_req.cmd == CMD_GET) && w_hit) ?
                                w_sel[0].data : '0;
        end
    end

    assign o_rsp_valid = r_rsp_valid;
    assign o_rsp       = r_rsp;

endmodule

`default_nettype wire

/* rtl/lkv_cell.sv */
`timescale 1ns / 1ps
`default_nettype none

// One position of the recency stack; position 0 is the most recent entry.
module lkv_cell import lkv_pkg::*; (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire t_cell_ctl           i_ctl,
    input  wire logic [KEY_BITS-1:0] i_key,
    input  wire logic                i_drop,
    input  wire t_entry              i_prev,
    input  wire logic                i_shift_above,
    input  wire t_entry              i_sel_above,
    output t_entry                   o_entry,
    output logic                     o_shift,
    output t_entry                   o_sel
);

    logic                  r_valid;
    logic [KEY_BITS-1:0]   r_key;
    logic [VALUE_BITS-1:0] r_data;
    logic                  r_match;
    logic                  w_take;

    // Take the neighbor's entry when a hit sits at or beyond this position,
    // or on an insertion.
    assign w_take = i_ctl.update && (i_ctl.ins_all || r_match || i_shift_above);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_match <= 1'b0;
        end else begin
            if (i_ctl.look) begin
                r_match <= r_valid && (r_key == i_key);
            end
            if (w_take) begin
                r_valid <= i_prev.valid && !i_drop;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_key  <= i_prev.key;
            r_data <= i_prev.data;
        end
    end

    assign o_entry = '{valid: r_valid, key: r_key, data: r_data};
    assign o_shift = r_match || i_shift_above;
    assign o_sel   = i_sel_above | (r_match ? o_entry : '0);

endmodule

`default_nettype wire

/* verif/tb.sv */
`timescale 1ns / 1ps

module tb;
    import lkv_pkg::*;

    localparam int RANK_BITS   = $clog2(ENTRIES);
    localparam int KEY_POOL    = 24;
    localparam int PHASES      = 8;
    localparam int PHASE_ITEMS = 212;
    localparam int CYCLE_LIMIT = 150000;
    localparam int TAIL_CYCLES = 12;

    typedef enum logic [1:0] {
        OP_ITEM,
        OP_CAP_WRITE,
        OP_DRAIN
    } op_kind_e;

    typedef struct {
        op_kind_e            kind;
        t_req                req;
        logic [CAP_BITS-1:0] cap;
        int                  gap_pct;
    } pending_op_t;

    logic                i_clk;
    logic                i_rst_n     = 1'b0;
    logic                start       = 1'b0;
    logic                busy;
    t_req                i_req       = '0;
    logic                o_rsp_valid;
    t_rsp                o_rsp;
    logic                i_cfg_valid = 1'b0;
    logic                o_cfg_ready;
    logic [CAP_BITS-1:0] i_cfg_data  = '0;

    lru_key_value_cache uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_req       (i_req),
        .o_rsp_valid (o_rsp_valid),
        .o_rsp       (o_rsp),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    // Shadow copy of the cache, owned by the driver block.
    logic                  cache_valid [ENTRIES];
    logic [KEY_BITS-1:0]   cache_key   [ENTRIES];
    logic [VALUE_BITS-1:0] cache_data  [ENTRIES];
    logic [RANK_BITS-1:0]  cache_rank  [ENTRIES];
    logic [CNT_BITS-1:0]   cache_count;
    logic [CAP_BITS-1:0]   cache_cap;

    pending_op_t pending_ops [$];
    t_rsp        rsp_expect  [$];

    int acc_count   = 0;
    int rsp_count   = 0;
    int err_count   = 0;
    int cycle_count = 0;
    int n_hits      = 0;
    int n_evicts    = 0;
    int n_cap_wr    = 0;
    int fill_gap    = 0;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Make slot the most recent; entries more recent than it age by one.
    function automatic void promote(int slot);
        for (int i = 0; i < ENTRIES; i++)
            if (cache_valid[i] && cache_rank[i] < cache_rank[slot])
                cache_rank[i]++;
        cache_rank[slot] = '0;
    endfunction

    function automatic t_rsp cache_access(t_req req);
        t_rsp rsp;
        int   slot;
        int   lim;
        rsp  = '0;
        slot = -1;
        lim  = (int'(cache_cap) > ENTRIES) ? ENTRIES : int'(cache_cap);
        for (int i = 0; i < ENTRIES; i++)
            if (slot < 0 && cache_valid[i] && cache_key[i] == req.key)
                slot = i;

        if (req.cmd == CMD_GET) begin
            if (slot >= 0) begin
                rsp.hit        = 1'b1;
                rsp.read_value = cache_data[slot];
                promote(slot);
            end
            return rsp;
        end

        if (slot >= 0) begin
            rsp.hit          = 1'b1;
            cache_data[slot] = req.value;
            promote(slot);
            return rsp;
        end

        // New key: evict the least recent entry if the count would pass capacity.
        if (int'(cache_count) + 1 > lim) begin
            if (cache_count == 0)
                return rsp;
            for (int i = 0; i < ENTRIES; i++)
                if (slot < 0 && cache_valid[i] &&
                    CNT_BITS'(cache_rank[i]) == cache_count - 1'b1)
                    slot = i;
            if (slot < 0)
                return rsp;
            cache_valid[slot] = 1'b0;
            cache_rank[slot]  = '0;
            cache_count--;
            n_evicts++;
        end else begin
            for (int i = 0; i < ENTRIES; i++)
                if (slot < 0 && !cache_valid[i])
                    slot = i;
            if (slot < 0)
                return rsp;
        end

        for (int i = 0; i < ENTRIES; i++)
            if (cache_valid[i])
                cache_rank[i]++;
        cache_valid[slot] = 1'b1;
        cache_key[slot]   = req.key;
        cache_data[slot]  = req.value;
        cache_rank[slot]  = '0;
        cache_count++;
        return rsp;
    endfunction

    task automatic push_item(logic cmd, logic [KEY_BITS-1:0] key,
                             logic [VALUE_BITS-1:0] value);
        pending_op_t op;
        op.kind      = OP_ITEM;
        op.req.cmd   = cmd;
        op.req.key   = key;
        op.req.value = value;
        op.cap       = '0;
        op.gap_pct   = fill_gap;
        pending_ops.push_back(op);
    endtask

    task automatic push_ctl(op_kind_e kind, logic [CAP_BITS-1:0] cap);
        pending_op_t op;
        op.kind    = kind;
        op.req     = '0;
        op.cap     = cap;
        op.gap_pct = fill_gap;
        pending_ops.push_back(op);
    endtask

    // Driver: present commands and capacity writes, predict each accepted command.
    always @(posedge i_clk) begin : drive
        pending_op_t         op;
        logic                next_start;
        logic                next_cfg;
        t_req                next_req;
        logic [CAP_BITS-1:0] next_cap;
        int                  took;
        t_rsp                want;
        if (!i_rst_n) begin
            for (int i = 0; i < ENTRIES; i++) begin
                cache_valid[i] = 1'b0;
                cache_rank[i]  = '0;
            end
            cache_count = '0;
            cache_cap   = CAP_RESET;
            start       <= 1'b0;
            i_cfg_valid <= 1'b0;
        end else begin
            next_start = start;
            next_cfg   = i_cfg_valid;
            next_req   = i_req;
            next_cap   = i_cfg_data;
            took       = 0;

            if (start && !busy) begin
                want = cache_access(i_req);
                rsp_expect.push_back(want);
                if (want.hit)
                    n_hits++;
                took       = 1;
                next_start = 1'b0;
            end
            if (i_cfg_valid && o_cfg_ready) begin
                cache_cap = i_cfg_data;
                n_cap_wr++;
                next_cfg  = 1'b0;
            end

            if (!next_start && !next_cfg && pending_ops.size() > 0) begin
                op = pending_ops[0];
                case (op.kind)
                    OP_ITEM: begin
                        if ($urandom_range(99) >= op.gap_pct) begin
                            next_start = 1'b1;
                            next_req   = op.req;
                            void'(pending_ops.pop_front());
                        end
                    end
                    OP_CAP_WRITE: begin
                        // Write only while no command is in flight.
                        if (!took && acc_count == rsp_count) begin
                            next_cfg = 1'b1;
                            next_cap = op.cap;
                            void'(pending_ops.pop_front());
                        end
                    end
                    default: begin
                        if (!took && acc_count == rsp_count)
                            void'(pending_ops.pop_front());
                    end
                endcase
            end

            acc_count   <= acc_count + took;
            start       <= next_start;
            i_req       <= next_req;
            i_cfg_valid <= next_cfg;
            i_cfg_data  <= next_cap;
        end
    end

    // Monitor: every strobed result must match the oldest prediction.
    always @(posedge i_clk) begin : watch
        t_rsp want;
        if (i_rst_n && o_rsp_valid) begin
            if (rsp_count >= acc_count) begin
                $error("unexpected result: hit %0d read_value %h", o_rsp.hit, o_rsp.read_value);
                err_count++;
            end else begin
                want = rsp_expect.pop_front();
                if (o_rsp.hit !== want.hit) begin
                    $error("hit: expected %0d, actual %0d", want.hit, o_rsp.hit);
                    err_count++;
                end
                if (o_rsp.read_value !== want.read_value) begin
                    $error("read_value: expected %h, actual %h",
                           want.read_value, o_rsp.read_value);
                    err_count++;
                end
                rsp_count <= rsp_count + 1;
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("tb: done, errors");
            $finish;
        end
    end

    initial begin : stimulus
        int                  phase_gap [4];
        logic [CAP_BITS-1:0] phase_cap [PHASES];
        logic [KEY_BITS-1:0] key_base;
        logic [KEY_BITS-1:0] key;
        logic                cmd;

        phase_gap = '{0, 50, 0, 19};
        phase_cap = '{5'd16, 5'd1, 5'd0, 5'd16, 5'd5, 5'd2, 5'd16, 5'd9};

        // Empty store with capacity zero: a new key goes in and out at once.
        push_ctl(OP_CAP_WRITE, 5'd0);
        push_item(CMD_PUT, 16'h0005, 64'h1111_2222_3333_4444);
        push_item(CMD_GET, 16'h0005, 64'h0);
        push_ctl(OP_CAP_WRITE, 5'd16);
        push_item(CMD_GET, 16'h0000, 64'h0);
        push_item(CMD_PUT, 16'h0000, 64'h0);
        push_item(CMD_PUT, 16'hFFFF, 64'hFFFF_FFFF_FFFF_FFFF);
        push_item(CMD_GET, 16'h0000, 64'h0);
        push_item(CMD_GET, 16'hFFFF, 64'h0);
        push_item(CMD_PUT, 16'hFFFF, 64'hA5A5_5A5A_0F0F_F0F0);
        push_item(CMD_GET, 16'hFFFF, 64'h0);
        // Value on a get is ignored.
        push_item(CMD_GET, 16'h1234, 64'hDEAD_BEEF_CAFE_F00D);
        push_item(CMD_PUT, 16'h1234, 64'h0123_4567_89AB_CDEF);
        push_item(CMD_PUT, 16'h0001, 64'h1);
        push_item(CMD_PUT, 16'h0002, 64'h2);
        // Lower capacity below the count: one eviction per new key only.
        push_ctl(OP_CAP_WRITE, 5'd2);
        push_item(CMD_PUT, 16'h0003, 64'h3);
        push_item(CMD_GET, 16'h0000, 64'h0);
        push_item(CMD_GET, 16'h1234, 64'h0);
        push_ctl(OP_CAP_WRITE, 5'd1);
        push_item(CMD_PUT, 16'h0004, 64'h4);
        push_item(CMD_GET, 16'h0004, 64'h0);
        push_ctl(OP_CAP_WRITE, 5'd0);
        push_item(CMD_PUT, 16'h0007, 64'h7);
        push_item(CMD_GET, 16'h0007, 64'h0);
        push_item(CMD_GET, 16'h0002, 64'h0);

        for (int p = 0; p < PHASES; p++) begin
            fill_gap = phase_gap[p % 4];
            case (p % 3)
                0:       key_base = 16'h0000;
                1:       key_base = 16'hFFFF;
                default: key_base = 16'($urandom);
            endcase
            push_ctl(OP_CAP_WRITE, phase_cap[p]);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                cmd = ($urandom_range(99) < 50) ? CMD_GET : CMD_PUT;
                if ($urandom_range(99) < 80)
                    key = key_base ^ 16'($urandom_range(KEY_POOL - 1));
                else
                    key = 16'($urandom);
                push_item(cmd, key, {$urandom, $urandom});
                // Hold off until the pipeline has emptied once per phase.
                if (n == PHASE_ITEMS / 2)
                    push_ctl(OP_DRAIN, '0);
            end
        end

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        do
            @(negedge i_clk);
        while (!(pending_ops.size() == 0 && !start && !i_cfg_valid &&
                 acc_count == rsp_count));
        repeat (TAIL_CYCLES) @(negedge i_clk);

        if (rsp_expect.size() != 0) begin
            $error("%0d predicted results never arrived", rsp_expect.size());
            err_count++;
        end

        $display("tb: %0d get/put commands checked, %0d hits, %0d evictions",
                 acc_count, n_hits, n_evicts);
        $display("tb: %0d capacity writes between 0 and 16, sender gaps 0/19/50 percent",
                 n_cap_wr);
        if (err_count == 0)
            $display("tb: done, clean");
        else
            $display("tb: done, errors");
        $finish;
    end

endmodule

/* files.f */
rtl/lkv_pkg.sv
rtl/lkv_cell.sv
rtl/lru_key_value_cache.sv
verif/tb.sv
